[src/tgv_pkg.sv]
package tgv_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 16;

   // derived fixed-point constants
   localparam int TWO_F      = 2 * FRAC_BITS;
   localparam int ATAN_COUNT = 31;
   localparam int CORDIC_NST = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;
   localparam int MOD_STEPS  = 60 - TWO_F;
   localparam int MOD_STAGES = MOD_STEPS / 2;
   localparam int TH_RSH     = (TWO_F >= 30) ? TWO_F - 30 : 0;
   localparam int TH_LSH     = (TWO_F >= 30) ? 0 : 30 - TWO_F;

   localparam logic [63:0] TWOPI_Q60 = 64'h6487ED5110B4611A;
   localparam logic [63:0] PERIOD    = TWOPI_Q60 >> (60 - TWO_F);

   localparam int ANG_W = 34;
   localparam int CS_W  = 33;

   localparam logic signed [ANG_W-1:0] PI30      = ANG_W'(TWOPI_Q60 >> 31);
   localparam logic signed [ANG_W-1:0] HALF_PI30 = ANG_W'(TWOPI_Q60 >> 32);
   localparam logic signed [ANG_W-1:0] TWOPI30   = ANG_W'(TWOPI_Q60 >> 30);
   localparam logic signed [CS_W-1:0]  KINV_Q30  = CS_W'(32'h26DD3B6A);

   // configuration register indexes
   localparam logic [7:0] REG_VELOCITY_SCALE = 8'd0;
   localparam logic [7:0] REG_INV_LENGTH     = 8'd1;

   // truncated Q30 arctangent of 2^-i
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   // clamp to signed 32 bits
   function automatic logic [31:0] sat32(input logic signed [51:0] v);
      logic [31:0] r;
      if (v > 52'sh7FFFFFFF) begin
         r = 32'h7FFFFFFF;
      end else if (v < -52'sh80000000) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[src/tgv_angle.sv]
module tgv_angle (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [31:0]                  pos,
   input  logic [30:0]                         inv_l,
   output logic                                out_valid,
   output logic signed [tgv_pkg::ANG_W-1:0]    theta,
   output logic                                neg
);

   localparam int NS = tgv_pkg::MOD_STAGES;

   logic signed [63:0] prod_ff;
   logic               v0_ff;
   logic [63:0]        rem_ff [NS+1];
   logic               sgn_ff [NS+1];
   logic               vm_ff  [NS+1];
   logic [63:0]        r_ff;
   logic               vr_ff;
   logic signed [tgv_pkg::ANG_W-1:0] th_ff;
   logic               neg_ff;
   logic               vth_ff;

   // scale the coordinate by 1/L
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
      if (en) begin
         prod_ff <= 64'(pos) * 64'($signed({1'b0, inv_l}));
      end
   end

   // take magnitude for the remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff[0] <= 1'b0;
      end else if (en) begin
         vm_ff[0] <= v0_ff;
      end
      if (en) begin
         rem_ff[0] <= prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
         sgn_ff[0] <= prod_ff[63];
      end
   end

   // restoring remainder against 2*pi, two steps per stage
   for (genvar s = 0; s < NS; s++) begin : g_mod
      localparam int K1 = tgv_pkg::MOD_STEPS - 1 - 2 * s;
      localparam logic [63:0] D1 = tgv_pkg::PERIOD << K1;
      localparam logic [63:0] D2 = tgv_pkg::PERIOD << (K1 - 1);
      logic [63:0] a_in;
      logic [63:0] b_in;
      always_comb begin
         a_in = (rem_ff[s] >= D1) ? rem_ff[s] - D1 : rem_ff[s];
         b_in = (a_in >= D2) ? a_in - D2 : a_in;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vm_ff[s+1] <= 1'b0;
         end else if (en) begin
            vm_ff[s+1] <= vm_ff[s];
         end
         if (en) begin
            rem_ff[s+1] <= b_in;
            sgn_ff[s+1] <= sgn_ff[s];
         end
      end
   end

   // map to floor remainder for negative products
   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
      end else if (en) begin
         vr_ff <= vm_ff[NS];
      end
      if (en) begin
         r_ff <= (sgn_ff[NS] && rem_ff[NS] != 64'd0) ? tgv_pkg::PERIOD - rem_ff[NS]
                                                     : rem_ff[NS];
      end
   end

   // convert to Q30 and fold into [-pi/2, pi/2]
   logic [63:0]                      r_sh;
   logic signed [tgv_pkg::ANG_W-1:0] t0;
   logic signed [tgv_pkg::ANG_W-1:0] t1;
   logic signed [tgv_pkg::ANG_W-1:0] th_in;
   logic                             neg_in;
   always_comb begin
      r_sh = (r_ff >> tgv_pkg::TH_RSH) << tgv_pkg::TH_LSH;
      t0   = $signed(r_sh[tgv_pkg::ANG_W-1:0]);
      t1   = (t0 > tgv_pkg::PI30) ? t0 - tgv_pkg::TWOPI30 : t0;
      th_in  = t1;
      neg_in = 1'b0;
      if (t1 > tgv_pkg::HALF_PI30) begin
         th_in  = t1 - tgv_pkg::PI30;
         neg_in = 1'b1;
      end else if (t1 < -tgv_pkg::HALF_PI30) begin
         th_in  = t1 + tgv_pkg::PI30;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vth_ff <= 1'b0;
      end else if (en) begin
         vth_ff <= vr_ff;
      end
      if (en) begin
         th_ff  <= th_in;
         neg_ff <= neg_in;
      end
   end

   assign out_valid = vth_ff;
   assign theta     = th_ff;
   assign neg       = neg_ff;

endmodule

[src/tgv_cordic.sv]
module tgv_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [tgv_pkg::ANG_W-1:0]   theta,
   input  logic                               neg,
   output logic                               out_valid,
   output logic signed [tgv_pkg::CS_W-1:0]    sin_q30,
   output logic signed [tgv_pkg::CS_W-1:0]    cos_q30
);

   localparam int NST = tgv_pkg::CORDIC_NST;

   logic signed [tgv_pkg::CS_W-1:0]  x_ff [NST+1];
   logic signed [tgv_pkg::CS_W-1:0]  y_ff [NST+1];
   logic signed [tgv_pkg::ANG_W-1:0] z_ff [NST+1];
   logic                             n_ff [NST+1];
   logic                             v_ff [NST+1];
   logic signed [tgv_pkg::CS_W-1:0]  s_ff;
   logic signed [tgv_pkg::CS_W-1:0]  c_ff;
   logic                             vo_ff;

   // seed the rotation
   always_comb begin
      x_ff[0] = tgv_pkg::KINV_Q30;
      y_ff[0] = '0;
      z_ff[0] = theta;
      n_ff[0] = neg;
      v_ff[0] = in_valid;
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < NST; i++) begin : g_rot
      localparam logic signed [tgv_pkg::ANG_W-1:0] ATAN =
         tgv_pkg::ANG_W'(tgv_pkg::atan_q30(5'(i)));
      logic signed [tgv_pkg::CS_W-1:0] xs;
      logic signed [tgv_pkg::CS_W-1:0] ys;
      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            n_ff[i+1] <= n_ff[i];
         end
      end
   end

   // undo the fold by pi
   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_ff[NST];
      end
      if (en) begin
         s_ff <= n_ff[NST] ? -y_ff[NST] : y_ff[NST];
         c_ff <= n_ff[NST] ? -x_ff[NST] : x_ff[NST];
      end
   end

   assign out_valid = vo_ff;
   assign sin_q30   = s_ff;
   assign cos_q30   = c_ff;

endmodule

[src/tgv_field.sv]
module tgv_field (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [tgv_pkg::CS_W-1:0]  sx,
   input  logic signed [tgv_pkg::CS_W-1:0]  cx,
   input  logic signed [tgv_pkg::CS_W-1:0]  sy,
   input  logic signed [tgv_pkg::CS_W-1:0]  cy,
   input  logic [30:0]                      vel_u,
   input  logic [30:0]                      inv_l,
   output logic                             out_valid,
   output logic [31:0]                      velocity_x,
   output logic [31:0]                      velocity_y,
   output logic [31:0]                      dudx,
   output logic [31:0]                      dudy,
   output logic [31:0]                      dvdx,
   output logic [31:0]                      dvdy
);

   localparam int FB = tgv_pkg::FRAC_BITS;

   // stage 1: trig products rounded to Q30
   logic signed [65:0] m_cs, m_sc, m_ss, m_cc;
   logic signed [65:0] r_cs, r_sc, r_ss, r_cc;
   logic signed [33:0] p_ff [4];
   logic               v1_ff;
   always_comb begin
      m_cs = 66'(cx) * 66'(sy);
      m_sc = 66'(sx) * 66'(cy);
      m_ss = 66'(sx) * 66'(sy);
      m_cc = 66'(cx) * 66'(cy);
      r_cs = (m_cs + 66'sd536870912) >>> 30;
      r_sc = (m_sc + 66'sd536870912) >>> 30;
      r_ss = (m_ss + 66'sd536870912) >>> 30;
      r_cc = (m_cc + 66'sd536870912) >>> 30;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         p_ff[0] <= r_cs[33:0];
         p_ff[1] <= r_sc[33:0];
         p_ff[2] <= r_ss[33:0];
         p_ff[3] <= r_cc[33:0];
      end
   end

   // stage 2: scale by U
   logic signed [65:0] up_ff [4];
   logic               v2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            up_ff[k] <= 66'(p_ff[k]) * 66'($signed({1'b0, vel_u}));
         end
      end
   end

   // stage 3: velocity shift, gradient times 1/L
   logic signed [65:0] vx_w, vy_w, t_ss, t_cc;
   logic signed [35:0] vx_ff, vy_ff;
   logic signed [67:0] gs_ff, gc_ff;
   logic               v3_ff;
   always_comb begin
      vx_w = (up_ff[0] + 66'sd1073741824) >>> 31;
      vy_w = (up_ff[1] + 66'sd1073741824) >>> 31;
      t_ss = (up_ff[2] + 66'sd536870912) >>> 30;
      t_cc = (up_ff[3] + 66'sd536870912) >>> 30;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         vx_ff <= vx_w[35:0];
         vy_ff <= -vy_w[35:0];
         gs_ff <= 68'($signed(t_ss[35:0])) * 68'($signed({1'b0, inv_l}));
         gc_ff <= 68'($signed(t_cc[35:0])) * 68'($signed({1'b0, inv_l}));
      end
   end

   // stage 4: round, negate and clamp
   logic signed [67:0] gs_w, gc_w;
   logic signed [51:0] gx, gy;
   logic [31:0]        o_ff [6];
   logic               v4_ff;
   always_comb begin
      gs_w = (gs_ff + (68'sd1 <<< FB)) >>> (FB + 1);
      gc_w = (gc_ff + (68'sd1 <<< FB)) >>> (FB + 1);
      gx   = -gs_w[51:0];
      gy   = gc_w[51:0];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         o_ff[0] <= tgv_pkg::sat32(52'(vx_ff));
         o_ff[1] <= tgv_pkg::sat32(52'(vy_ff));
         o_ff[2] <= tgv_pkg::sat32(gx);
         o_ff[3] <= tgv_pkg::sat32(gy);
         o_ff[4] <= tgv_pkg::sat32(-gy);
         o_ff[5] <= tgv_pkg::sat32(-gx);
      end
   end

   assign out_valid  = v4_ff;
   assign velocity_x = o_ff[0];
   assign velocity_y = o_ff[1];
   assign dudx       = o_ff[2];
   assign dudy       = o_ff[3];
   assign dvdx       = o_ff[4];
   assign dvdy       = o_ff[5];

endmodule

[src/taylor_green_velocity_gradient_unit.sv]
// channel   dir  handshake                 payload
// req       in   req_tvalid/req_tready     req_tdata: x_position, y_position
// rsp       out  rsp_tvalid/rsp_tready     rsp_tdata: six Q16.16 results
// csr       in   csr_valid/csr_ready       csr_index, csr_data
//
// One point per cycle unless rsp stalls; the path runs through the remainder divider
// (two steps a stage) and the CORDIC chain.
// Reset clears the valid bits and loads U = 1/L = 1.0.
// A stall on rsp freezes the whole pipeline; nothing is dropped or repeated.
module taylor_green_velocity_gradient_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // [31:0] x_position, [63:32] y_position
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // velocity_x, velocity_y, dudx, dudy, dvdx, dvdy
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [31:0]  csr_data
);

   logic [30:0] vel_u_ff;
   logic [30:0] inv_l_ff;
   logic        en;

   // write configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         vel_u_ff <= 31'd65536;
         inv_l_ff <= 31'd65536;
      end else if (csr_valid) begin
         if (csr_index == tgv_pkg::REG_VELOCITY_SCALE) begin
            vel_u_ff <= csr_data[30:0];
         end else if (csr_index == tgv_pkg::REG_INV_LENGTH) begin
            inv_l_ff <= csr_data[30:0];
         end
      end
   end

   // advance when the output word is empty or taken
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic                             ax_v, ay_v, cx_v, cy_v;
   logic signed [tgv_pkg::ANG_W-1:0] thx, thy;
   logic                             ngx, ngy;
   logic signed [tgv_pkg::CS_W-1:0]  sx, cx, sy, cy;
   logic [31:0] o_vx, o_vy, o_dudx, o_dudy, o_dvdx, o_dvdy;

   tgv_angle u_ang_x (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_tvalid),
      .pos($signed(req_tdata[31:0])), .inv_l(inv_l_ff),
      .out_valid(ax_v), .theta(thx), .neg(ngx)
   );

   tgv_angle u_ang_y (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_tvalid),
      .pos($signed(req_tdata[63:32])), .inv_l(inv_l_ff),
      .out_valid(ay_v), .theta(thy), .neg(ngy)
   );

   tgv_cordic u_cor_x (
      .clock(clock), .reset(reset), .en(en), .in_valid(ax_v),
      .theta(thx), .neg(ngx), .out_valid(cx_v), .sin_q30(sx), .cos_q30(cx)
   );

   tgv_cordic u_cor_y (
      .clock(clock), .reset(reset), .en(en), .in_valid(ay_v && ax_v),
      .theta(thy), .neg(ngy), .out_valid(cy_v), .sin_q30(sy), .cos_q30(cy)
   );

   tgv_field u_field (
      .clock(clock), .reset(reset), .en(en), .in_valid(cx_v && cy_v),
      .sx(sx), .cx(cx), .sy(sy), .cy(cy), .vel_u(vel_u_ff), .inv_l(inv_l_ff),
      .out_valid(rsp_tvalid),
      .velocity_x(o_vx), .velocity_y(o_vy), .dudx(o_dudx), .dudy(o_dudy),
      .dvdx(o_dvdx), .dvdy(o_dvdy)
   );

   assign rsp_tdata = {o_dvdy, o_dvdx, o_dudy, o_dudx, o_vy, o_vx};

endmodule
